/* hw/rtl/class_data_uleb128_decoder_macros.svh */
// Assertion macros for the class-data decoder.
// Included by RTL files that check their own behaviour; no other dependency.
`ifndef CLASS_DATA_ULEB128_DECODER_MACROS_SVH
`define CLASS_DATA_ULEB128_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define CDU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("class data decoder: same-cycle check failed");
`define CDU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("class data decoder: next-cycle check failed");
`else
`define CDU_ASSERT_SAME(label, clk, rst, ante, cons)
`define CDU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/cdu_pkg.sv */
// Shared types and codes of the class-data decoder.
// No dependencies.
`default_nettype none
package cdu_pkg;

  localparam logic [2:0] PHASE_FIRST_COUNT = 3'd0;
  localparam logic [2:0] PHASE_ENTRY = 3'd4;
  localparam logic [2:0] PHASE_LAST_COUNT = 3'd3;

  localparam logic [1:0] PART_DELTA  = 2'd0;
  localparam logic [1:0] PART_ACCESS = 2'd1;
  localparam logic [1:0] PART_OFFSET = 2'd2;

  localparam logic [2:0] SEC_EMPTY = 3'd4;
  localparam logic [2:0] LIST_NONE = 3'd4;
  localparam logic [1:0] LIST_STATIC = 2'd0;
  localparam logic [1:0] LIST_FIRST_METHOD = 2'd2;

  localparam logic [7:0] LEB_DATA_MASK = 8'h7f;
  localparam logic [7:0] LEB_LAST_MASK = 8'h0f;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } leb_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  section;
    logic [31:0] member_index;
    logic [31:0] access_flags;
    logic [31:0] code_offset;
    logic        record_last;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/cdu_leb.sv */
// Unsigned LEB128 value assembly, one byte per word, up to five bytes.
// Depends on cdu_pkg.
`default_nettype none
module cdu_leb
  import cdu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  output leb_t            leb
);

  logic [31:0] accumulator;
  logic [2:0]  byte_position;
  logic [31:0] base;
  logic [31:0] part;

  always_comb begin
    base = (byte_position == 3'd0) ? 32'd0 : accumulator;
    part = 32'd0;
    leb.done = ~data_byte[7];
    case (byte_position)
      3'd0: part = {24'd0, data_byte & LEB_DATA_MASK};
      3'd1: part = {17'd0, data_byte[6:0], 8'd0} >> 1;
      3'd2: part = {10'd0, data_byte[6:0], 15'd0} >> 1;
      3'd3: part = {3'd0, data_byte[6:0], 22'd0} >> 1;
      3'd4: begin
        part = {data_byte[3:0] & LEB_LAST_MASK[3:0], 28'd0};
        leb.done = 1'b1;
      end
      default: part = {24'd0, data_byte & LEB_DATA_MASK};
    endcase
    if (byte_position > 3'd4) begin
      base = 32'd0;
    end
    leb.value = base | part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      accumulator <= 32'd0;
    end else if (fire) begin
      accumulator <= leb.value;
      if (leb.done || byte_position > 3'd4) begin
        byte_position <= leb.done ? 3'd0 : 3'd1;
      end else begin
        byte_position <= byte_position + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cdu_parser.sv */
// Record walker: counts, running index and entry fields of a class-data record.
// Depends on cdu_pkg; takes finished values from cdu_leb.
`default_nettype none
module cdu_parser
  import cdu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire leb_t  leb,
  output result_t    res
);

  logic [31:0] counts [4];
  logic [31:0] counts_next [4];
  logic [2:0]  phase, phase_next;
  logic [1:0]  current_list, current_list_next;
  logic [1:0]  entry_part, entry_part_next;
  logic [31:0] running_index, running_index_next;
  logic [31:0] held_access, held_access_next;

  logic [3:0]  nonzero;
  logic [3:0]  nonzero_first;
  logic [1:0]  count_slot;
  logic [2:0]  list_found;
  logic [31:0] entry_access;

  function automatic logic [2:0] next_list(input logic [3:0] nz, input logic [2:0] start);
    logic [2:0] found;
    found = LIST_NONE;
    for (int k = 3; k >= 0; k--) begin
      if (nz[k] && 3'(k) >= start) begin
        found = 3'(k);
      end
    end
    return found;
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nonzero[k] = counts[k] != 32'd0;
      counts_next[k] = counts[k];
    end
    nonzero_first = {leb.value != 32'd0, nonzero[2:0]};
    count_slot = (phase < PHASE_ENTRY) ? phase[1:0] : 2'd0;
    phase_next = phase;
    current_list_next = current_list;
    entry_part_next = entry_part;
    running_index_next = running_index;
    held_access_next = held_access;
    list_found = LIST_NONE;
    entry_access = (entry_part == PART_ACCESS) ? leb.value : held_access;
    res = '0;
    res.section = {1'b0, current_list};
    res.member_index = running_index;
    res.access_flags = entry_access;

    if (fire && leb.done) begin
      if (phase != PHASE_ENTRY) begin
        counts_next[count_slot] = leb.value;
        if (count_slot != PHASE_LAST_COUNT[1:0]) begin
          phase_next = {1'b0, count_slot} + 3'd1;
        end else begin
          list_found = next_list(nonzero_first, 3'd0);
          running_index_next = 32'd0;
          entry_part_next = PART_DELTA;
          if (list_found == LIST_NONE) begin
            phase_next = PHASE_FIRST_COUNT;
            current_list_next = LIST_STATIC;
            res.valid = 1'b1;
            res.section = SEC_EMPTY;
            res.member_index = 32'd0;
            res.access_flags = 32'd0;
            res.record_last = 1'b1;
          end else begin
            phase_next = PHASE_ENTRY;
            current_list_next = list_found[1:0];
          end
        end
      end else if (entry_part == PART_DELTA) begin
        running_index_next = running_index + leb.value;
        entry_part_next = PART_ACCESS;
      end else if (entry_part == PART_ACCESS && current_list >= LIST_FIRST_METHOD) begin
        held_access_next = leb.value;
        entry_part_next = PART_OFFSET;
      end else begin
        if (entry_part == PART_ACCESS) begin
          held_access_next = leb.value;
        end else begin
          res.code_offset = leb.value;
        end
        res.valid = 1'b1;
        counts_next[current_list] = counts[current_list] - 32'd1;
        entry_part_next = PART_DELTA;
        if (counts[current_list] == 32'd1) begin
          running_index_next = 32'd0;
          list_found = next_list(nonzero, {1'b0, current_list} + 3'd1);
          if (list_found == LIST_NONE) begin
            res.record_last = 1'b1;
            phase_next = PHASE_FIRST_COUNT;
            current_list_next = LIST_STATIC;
          end else begin
            current_list_next = list_found[1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        counts[k] <= 32'd0;
      end
      phase <= PHASE_FIRST_COUNT;
      current_list <= LIST_STATIC;
      entry_part <= PART_DELTA;
      running_index <= 32'd0;
      held_access <= 32'd0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        counts[k] <= counts_next[k];
      end
      phase <= phase_next;
      current_list <= current_list_next;
      entry_part <= entry_part_next;
      running_index <= running_index_next;
      held_access <= held_access_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/class_data_uleb128_decoder.sv */
// Class-data record decoder, top level: input register, LEB128 assembly,
// record walker and result register.
// Depends on cdu_pkg, cdu_leb, cdu_parser and the assertion macro header.
//
// Usage:
//   Input channel: data_byte with in_valid / in_stall; a word moves at a rising
//   edge with in_valid high and in_stall low. One word is one record byte.
//   Output channel: section, member_index, access_flags, code_offset and
//   record_last with out_valid / out_stall; one word per finished entry, or a
//   single word with section 4 for a record whose four counts are all zero.
//   Path: the byte that ends an entry waits in the input register, and its result
//   in the result register, before the result can be taken. Throughput: one
//   byte per cycle while no result is held by out_stall; the value accumulator
//   and the record walker each update once per byte.
//   Stall: while out_stall holds a result, the byte in the input register
//   waits and in_stall rises, so at most one further byte is taken.
//   Reset (rst, synchronous): both registers empty, decoding restarts at the
//   first count of a new record.
`default_nettype none
`include "class_data_uleb128_decoder_macros.svh"
module class_data_uleb128_decoder
  import cdu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       section,
  output logic [31:0]      member_index,
  output logic [31:0]      access_flags,
  output logic [31:0]      code_offset,
  output logic             record_last
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  leb_t       leb;
  result_t    res;

  assign advance = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= data_byte;
    end
  end

  cdu_leb u_leb (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .data_byte (held_byte),
    .leb       (leb)
  );

  cdu_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .leb  (leb),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      section <= res.section;
      member_index <= res.member_index;
      access_flags <= res.access_flags;
      code_offset <= res.code_offset;
      record_last <= res.record_last;
    end
  end

  `CDU_ASSERT_NEXT(a_held_byte_waits, clk, rst, held_valid && !advance,
                   held_valid && $stable(held_byte))
  `CDU_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall,
                   out_valid && $stable(member_index) && $stable(section))
  `CDU_ASSERT_SAME(a_free_output_takes, clk, rst, out_valid && !out_stall, !in_stall)
  `CDU_ASSERT_SAME(a_stall_needs_byte, clk, rst, in_stall, held_valid && out_valid)

endmodule
`default_nettype wire
